### rtl/gfmip_pkg.sv
// Package for the GF(2^8) multiply, inverse and power unit.
// Holds the opcodes, the pipeline item type and the field helper functions.
// Depends on nothing.
package gfmip_pkg;

    localparam int NUM_STAGES = 32;
    localparam logic [8:0] MODULUS_RESET = 9'h1C3;
    localparam logic [8:0] MODULUS_TOP = 9'h100;

    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_INV = 2'd1;
    localparam logic [1:0] OP_POW = 2'd2;

    typedef struct packed {
        logic        valid;
        logic [1:0]  op;
        logic [7:0]  acc;
        logic [7:0]  base;
        logic [15:0] exp;
        logic [8:0]  u;
        logic [8:0]  v;
        logic [7:0]  su;
        logic [7:0]  sv;
    } t_item;

    function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y,
                                          input logic [8:0] m);
        logic [15:0] p;
        p = 16'd0;
        for (int i = 0; i < 8; i++) begin
            if (y[i]) begin
                p = p ^ ({8'd0, x} << i);
            end
        end
        for (int b = 15; b >= 8; b--) begin
            if (p[b]) begin
                p = p ^ ({7'd0, m} << (b - 8));
            end
        end
        return p[7:0];
    endfunction

    function automatic logic [3:0] poly_len(input logic [8:0] x);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 9; i++) begin
            if (x[i]) begin
                n = 4'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

### rtl/gf256_multiply_inverse_power.sv
// Top level of the GF(2^8) multiply, inverse and power unit.
// Depends on gfmip_pkg and gfmip_stage.
//
//  channel  | ports                                         | transfer when
//  command  | start, i_opcode, i_operand_a/b, i_exponent    | start && !busy
//  result   | o_result_valid, o_result                      | o_result_valid
//  config   | i_cfg_wr_en, i_cfg_wr_data                    | i_cfg_wr_en
//
// Each item passes 32 multiplier stages, one per squaring or multiply of the
// exponent scan, and then an output register, from which its result drives
// the ports.
// A new item is taken every cycle, so busy stays low. Synchronous reset clears
// the stage valid bits and loads the modulus 0x1C3. Results cannot be stalled.
module gf256_multiply_inverse_power (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_operand_a,
    input  logic [7:0]  i_operand_b,
    input  logic [15:0] i_exponent,
    input  logic        i_cfg_wr_en,
    input  logic [8:0]  i_cfg_wr_data,
    output logic        o_result_valid,
    output logic [7:0]  o_result
);

    logic [8:0]       r_modulus;
    logic             r_result_valid;
    logic [7:0]       r_result;
    logic [7:0]       n_result;
    gfmip_pkg::t_item w_stage [0:gfmip_pkg::NUM_STAGES];

    assign busy = 1'b0;

    assign w_stage[0].valid = start;
    assign w_stage[0].op    = i_opcode;
    assign w_stage[0].acc   = (i_opcode == gfmip_pkg::OP_MUL) ? i_operand_a : 8'd1;
    assign w_stage[0].base  = (i_opcode == gfmip_pkg::OP_MUL) ? i_operand_b : i_operand_a;
    assign w_stage[0].exp   = i_exponent;
    assign w_stage[0].u     = {1'b0, i_operand_a};
    assign w_stage[0].v     = r_modulus;
    assign w_stage[0].su    = 8'd1;
    assign w_stage[0].sv    = 8'd0;

    genvar g;
    generate
        for (g = 0; g < gfmip_pkg::NUM_STAGES; g++) begin : g_stage
            logic w_mul_en;
            if (g % 2 == 0) begin : g_sq
                assign w_mul_en = (w_stage[g].op == gfmip_pkg::OP_POW);
            end else begin : g_mul
                assign w_mul_en = ((w_stage[g].op == gfmip_pkg::OP_POW) &&
                                   w_stage[g].exp[15 - g / 2]) ||
                                  ((g == 1) && (w_stage[g].op == gfmip_pkg::OP_MUL));
            end
            gfmip_stage u_stage (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_modulus (r_modulus),
                .i_square  (g % 2 == 0),
                .i_mul_en  (w_mul_en),
                .i_item    (w_stage[g]),
                .o_item    (w_stage[g + 1])
            );
        end
    endgenerate

    always_comb begin
        unique case (w_stage[gfmip_pkg::NUM_STAGES].op)
            gfmip_pkg::OP_MUL: n_result = w_stage[gfmip_pkg::NUM_STAGES].acc;
            gfmip_pkg::OP_POW: n_result = w_stage[gfmip_pkg::NUM_STAGES].acc;
            gfmip_pkg::OP_INV: n_result = w_stage[gfmip_pkg::NUM_STAGES].su;
            default:           n_result = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (!i_rst_n) begin
            r_modulus      <= gfmip_pkg::MODULUS_RESET;
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= w_stage[gfmip_pkg::NUM_STAGES].valid;
            if (i_cfg_wr_en) begin
                r_modulus <= i_cfg_wr_data | gfmip_pkg::MODULUS_TOP;
            end
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

endmodule

### rtl/gfmip_stage.sv
// One pipeline stage: one field multiply and one Euclid reduction step.
// Depends on gfmip_pkg for the item type and field functions.
module gfmip_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [8:0]          i_modulus,
    input  logic                i_square,
    input  logic                i_mul_en,
    input  gfmip_pkg::t_item    i_item,
    output gfmip_pkg::t_item    o_item
);

    gfmip_pkg::t_item r_item;
    gfmip_pkg::t_item n_item;
    logic [8:0] w_u;
    logic [8:0] w_v;
    logic [7:0] w_su;
    logic [7:0] w_sv;
    logic [3:0] w_shift;
    logic       w_swap;

    assign w_swap = (i_item.v != 9'd0) &&
                    (gfmip_pkg::poly_len(i_item.u) < gfmip_pkg::poly_len(i_item.v));
    assign w_u  = w_swap ? i_item.v  : i_item.u;
    assign w_v  = w_swap ? i_item.u  : i_item.v;
    assign w_su = w_swap ? i_item.sv : i_item.su;
    assign w_sv = w_swap ? i_item.su : i_item.sv;
    assign w_shift = gfmip_pkg::poly_len(w_u) - gfmip_pkg::poly_len(w_v);

    always_comb begin
        n_item = i_item;
        if (i_mul_en) begin
            n_item.acc = gfmip_pkg::gf_mul(i_item.acc, i_square ? i_item.acc : i_item.base,
                                           i_modulus);
        end
        n_item.u  = w_u;
        n_item.v  = w_v;
        n_item.su = w_su;
        n_item.sv = w_sv;
        if (w_v != 9'd0) begin
            n_item.u  = w_u ^ (w_v << w_shift);
            n_item.su = w_su ^ (w_sv << w_shift);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item <= '0;
        end else begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule
